[hdl/ngc_pkg.sv]
package ngc_pkg;

    // block geometry
    localparam int NIBS           = 32;
    localparam int HALF           = 16;
    localparam int BLOCK_W        = 128;
    localparam int WORD_W         = 64;
    localparam int RC_LEN         = 41;
    localparam int ROUNDS_DEFAULT = 41;
    localparam int CFG_INDEX_W    = 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1
    } cfg_reg_t;

    // block and key as 32 nibbles, nibble i at bits 4i+3..4i
    typedef logic [NIBS-1:0][3:0] block_t;

    // 4-bit substitution
    localparam logic [3:0] SBOX [16] = '{
        4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
        4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
    };

    // nibble j moves to position PERM[j]
    localparam logic [4:0] PERM [NIBS] = '{
        5'd31, 5'd6,  5'd29, 5'd14, 5'd1,  5'd12, 5'd21, 5'd8,
        5'd27, 5'd2,  5'd3,  5'd0,  5'd25, 5'd4,  5'd23, 5'd10,
        5'd15, 5'd22, 5'd13, 5'd30, 5'd17, 5'd28, 5'd5,  5'd24,
        5'd11, 5'd18, 5'd19, 5'd16, 5'd9,  5'd20, 5'd7,  5'd26
    };

    // round constants for nibble 1
    localparam logic [3:0] RCA [RC_LEN] = '{
        4'h0, 4'h0, 4'h1, 4'h3, 4'h7, 4'hf, 4'hf, 4'hf, 4'he, 4'hd, 4'ha,
        4'h5, 4'ha, 4'h5, 4'hb, 4'h6, 4'hc, 4'h9, 4'h3, 4'h6, 4'hd, 4'hb,
        4'h7, 4'he, 4'hd, 4'hb, 4'h6, 4'hd, 4'ha, 4'h4, 4'h9, 4'h2, 4'h4,
        4'h9, 4'h3, 4'h7, 4'he, 4'hc, 4'h8, 4'h1, 4'h2
    };

    // round constants for nibble 3
    localparam logic [3:0] RCB [RC_LEN] = '{
        4'h4, 4'hc, 4'hc, 4'hc, 4'hc, 4'hc, 4'h8, 4'h4, 4'h8, 4'h4, 4'h8,
        4'h4, 4'hc, 4'h8, 4'h0, 4'h4, 4'hc, 4'h8, 4'h4, 4'hc, 4'hc, 4'h8,
        4'h4, 4'hc, 4'h8, 4'h4, 4'h8, 4'h0, 4'h4, 4'h8, 4'h0, 4'h4, 4'hc,
        4'hc, 4'h8, 4'h0, 4'h0, 4'h4, 4'h8, 4'h4, 4'hc
    };

    // constants past the end of the table read as zero
    function automatic logic [3:0] rc_a(input int r);
        logic [3:0] v;
        v = 4'h0;
        if (r >= 0 && r < RC_LEN)
        begin
            v = RCA[r];
        end
        return v;
    endfunction

    function automatic logic [3:0] rc_b(input int r);
        logic [3:0] v;
        v = 4'h0;
        if (r >= 0 && r < RC_LEN)
        begin
            v = RCB[r];
        end
        return v;
    endfunction

endpackage

[hdl/ngc_key_regs.sv]
module ngc_key_regs
    import ngc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    output block_t                 key
);

    logic [WORD_W-1:0] key_low_reg;
    logic [WORD_W-1:0] key_high_reg;

    // register decode, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign key = block_t'({key_high_reg, key_low_reg});

endmodule

[hdl/ngc_round.sv]
module ngc_round
    import ngc_pkg::*;
#(
    parameter int ROUND_IDX  = 0,
    parameter bit LAST_ROUND = 1'b0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  block_t in_state,
    input  block_t key,
    output logic   out_valid,
    output block_t out_state
);

    localparam int KEY_BASE = (ROUND_IDX % 2) * HALF;

    logic   valid_reg;
    block_t state_reg;
    block_t mixed;
    block_t state_next;

    // feistel mix of even nibbles into odd ones, then round constants
    always_comb
    begin
        mixed = in_state;
        for (int j = 0; j < HALF; j++)
        begin
            mixed[2*j+1] = in_state[2*j+1] ^ SBOX[in_state[2*j]] ^ key[KEY_BASE + j];
        end
        mixed[1] = mixed[1] ^ rc_a(ROUND_IDX);
        mixed[3] = mixed[3] ^ rc_b(ROUND_IDX);
    end

    // nibble shuffle, skipped in the final round
    always_comb
    begin
        state_next = mixed;
        if (!LAST_ROUND)
        begin
            for (int j = 0; j < NIBS; j++)
            begin
                state_next[PERM[j]] = mixed[j];
            end
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

[hdl/nibble_gfn_cipher128_encrypt.sv]
// channel  | signals                                   | direction | handshake
// ---------+-------------------------------------------+-----------+----------------------
// input    | start, busy, plaintext_low/high          | in        | start && !busy
// result   | done, ciphertext_low/high                | out       | done, one cycle
// config   | cfg_write, cfg_index, cfg_data           | in        | cfg_write
//
// one word accepted every cycle; busy is always low
// the path is one input register, then one register per round
// each round stage holds one word, so throughput is set by the round pipeline
// reset clears the stage valid bits and both key registers
// results leave on done for exactly one cycle; the receiver cannot stall
module nibble_gfn_cipher128_encrypt
    import ngc_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [WORD_W-1:0]      plaintext_low,
    input  logic [WORD_W-1:0]      plaintext_high,
    output logic                   done,
    output logic [WORD_W-1:0]      ciphertext_low,
    output logic [WORD_W-1:0]      ciphertext_high,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    block_t key;
    logic   in_valid_reg;
    block_t in_state_reg;
    logic   stage_valid [ROUNDS+1];
    block_t stage_state [ROUNDS+1];

    // key registers
    ngc_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        in_state_reg <= block_t'({plaintext_high, plaintext_low});
    end

    assign stage_valid[0] = in_valid_reg;
    assign stage_state[0] = in_state_reg;

    // one registered stage per round
    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        ngc_round #(
            .ROUND_IDX  (r),
            .LAST_ROUND (r == ROUNDS - 1)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[r]),
            .in_state  (stage_state[r]),
            .key       (key),
            .out_valid (stage_valid[r+1]),
            .out_state (stage_state[r+1])
        );
    end

    // result word
    assign busy            = 1'b0;
    assign done            = stage_valid[ROUNDS];
    assign ciphertext_low  = stage_state[ROUNDS][HALF-1:0];
    assign ciphertext_high = stage_state[ROUNDS][NIBS-1:HALF];

endmodule
